// ===== hdl/grid_slot_assigner_assert.svh =====
// ---------------------------------------------------------------------------
// grid_slot_assigner assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef GRID_SLOT_ASSIGNER_ASSERT_SVH
`define GRID_SLOT_ASSIGNER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define GSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define GSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gsa_pkg.sv =====
// ---------------------------------------------------------------------------
// gsa_pkg
// Field widths and header and result codes of the grid slot assigner.
// ---------------------------------------------------------------------------
package gsa_pkg;

   localparam int ID_W   = 16;
   localparam int IP_W   = 32;
   localparam int MSG_W  = 8;
   localparam int LINK_W = 3;
   localparam int IN_W   = ID_W + IP_W;

   // Advertisement header: base code with the direction in the low bits.
   localparam logic [MSG_W-1:0] MSG_BASE = MSG_W'(2 << 3);
   localparam logic [MSG_W-1:0] DIR_UP   = MSG_W'(0);
   localparam logic [MSG_W-1:0] DIR_LEFT = MSG_W'(3);

   localparam logic [LINK_W-1:0] LINKS_CORNER = LINK_W'(2);
   localparam logic [LINK_W-1:0] LINKS_EDGE   = LINK_W'(3);
   localparam logic [LINK_W-1:0] LINKS_INNER  = LINK_W'(4);

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_ADVERT = 1'b1;

endpackage

// ===== hdl/grid_slot_assigner.sv =====
// ---------------------------------------------------------------------------
// grid_slot_assigner
// Places joining nodes on a square grid and advertises them to neighbors.
// ---------------------------------------------------------------------------
// Each join request carries a node id and an IPv4 address. The block gives
// the node the next slot of a square grid of side up to MAX_SIDE that grows
// one shell at a time (down the new right column, then across the new bottom
// row), stores the id in the slot table, and answers with up to three
// results: an advertisement to the up neighbor when the row is not zero, an
// advertisement to the left neighbor when the column is not zero, and a
// placement report (slot and link count) marked with tlast. When every slot
// is taken the request is answered by a single report with the grid-full flag
// set and nothing is stored. Requests are handled one at a time: the block
// takes a new request only back in its idle state, after the write step, one
// step per advertisement and the report step, or after the write step alone
// for a request dropped on a full grid. The slot table is a memory with one
// read port and a registered read, which is read once per neighbor, and
// every result passes through the single result register. Back pressure on
// the result side stalls these steps. The slot table is not cleared; a
// neighbor is always placed before the slot next to it, so only written
// entries are ever read.
// ---------------------------------------------------------------------------
`include "grid_slot_assigner_assert.svh"

module grid_slot_assigner
   import gsa_pkg::*;
#(
   parameter int MAX_SIDE = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // node_id [15:0], node_ip [47:16]
   input  logic [IN_W-1:0]             req_tdata,
   // Result channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // target_id, message_byte, advertised_ip, slot_x, slot_y, link_count,
   // from the lowest bit up, zero padded to whole bytes
   output logic [((ID_W + MSG_W + IP_W + 2 * $clog2(MAX_SIDE) + LINK_W + 7) / 8) * 8 - 1:0]
                                       rsp_tdata,
   // result_kind [0], grid_full [1]
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int COORD_W = $clog2(MAX_SIDE);
   localparam int SLOTS   = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int OUT_W   = ((ID_W + MSG_W + IP_W + 2 * COORD_W + LINK_W + 7) / 8) * 8;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WRITE  = 3'd1;
   localparam logic [2:0] S_UP     = 3'd2;
   localparam logic [2:0] S_LEFT   = 3'd3;
   localparam logic [2:0] S_REPORT = 3'd4;

   logic [2:0] state_ff, state_in;

   // Request held for the length of its processing.
   logic [ID_W-1:0]    id_ff, id_in;
   logic [IP_W-1:0]    ip_ff, ip_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic               full_ff, full_in;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic               out_kind_ff, out_kind_in;
   logic [ID_W-1:0]    out_tgt_ff, out_tgt_in;
   logic [MSG_W-1:0]   out_msg_ff, out_msg_in;
   logic [IP_W-1:0]    out_ip_ff, out_ip_in;
   logic [COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [LINK_W-1:0]  out_links_ff, out_links_in;
   logic               out_full_ff, out_full_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic               req_accept;
   logic               step;
   logic [COORD_W-1:0] cur_x, cur_y;
   logic               cur_full;

   logic               ram_we;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [ID_W-1:0]    ram_rdata;

   gsa_cursor #(
      .MAX_SIDE (MAX_SIDE)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cur_x     (cur_x),
      .cur_y     (cur_y),
      .grid_full (cur_full)
   );

   // Slot table, one node id per slot at index y * MAX_SIDE + x.
   gsa_ram #(
      .WIDTH (ID_W),
      .DEPTH (SLOTS)
   ) u_slot_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (id_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The result register takes a new result when it is empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      ip_in        = ip_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      idx_in       = idx_ff;
      full_in      = full_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_tgt_in   = out_tgt_ff;
      out_msg_in   = out_msg_ff;
      out_ip_in    = out_ip_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_links_in = out_links_ff;
      out_full_in  = out_full_ff;
      out_last_in  = out_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff - ADDR_W'(MAX_SIDE);
      step         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               id_in    = req_tdata[ID_W-1:0];
               ip_in    = req_tdata[IN_W-1:ID_W];
               x_in     = cur_x;
               y_in     = cur_y;
               idx_in   = ADDR_W'(ADDR_W'(cur_y) * ADDR_W'(MAX_SIDE) + ADDR_W'(cur_x));
               full_in  = cur_full;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (full_ff) begin
               // Dropped request: one report with only the full flag and tlast.
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = KIND_REPORT;
                  out_tgt_in   = '0;
                  out_msg_in   = '0;
                  out_ip_in    = '0;
                  out_x_in     = '0;
                  out_y_in     = '0;
                  out_links_in = '0;
                  out_full_in  = 1'b1;
                  out_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               // Store the id and start the first neighbor read together.
               ram_we = 1'b1;
               if (y_ff != '0) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff - ADDR_W'(MAX_SIDE);
                  state_in  = S_UP;
               end else if (x_ff != '0) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff - ADDR_W'(1);
                  state_in  = S_LEFT;
               end else begin
                  state_in = S_REPORT;
               end
            end
         end
         S_UP, S_LEFT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_ADVERT;
               out_tgt_in   = ram_rdata;
               out_msg_in   = MSG_BASE | ((state_ff == S_UP) ? DIR_UP : DIR_LEFT);
               out_ip_in    = ip_ff;
               out_x_in     = '0;
               out_y_in     = '0;
               out_links_in = '0;
               out_full_in  = 1'b0;
               out_last_in  = 1'b0;
               // After the up neighbor, fetch the left one if there is one.
               if (state_ff == S_UP && x_ff != '0) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff - ADDR_W'(1);
                  state_in  = S_LEFT;
               end else begin
                  state_in = S_REPORT;
               end
            end
         end
         S_REPORT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_REPORT;
               out_tgt_in   = '0;
               out_msg_in   = '0;
               out_ip_in    = '0;
               out_x_in     = x_ff;
               out_y_in     = y_ff;
               if (x_ff == '0 && y_ff == '0) begin
                  out_links_in = LINKS_CORNER;
               end else if (x_ff == '0 || y_ff == '0) begin
                  out_links_in = LINKS_EDGE;
               end else begin
                  out_links_in = LINKS_INNER;
               end
               out_full_in = 1'b0;
               out_last_in = 1'b1;
               step        = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      ip_ff        <= ip_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      idx_ff       <= idx_in;
      full_ff      <= full_in;
      out_kind_ff  <= out_kind_in;
      out_tgt_ff   <= out_tgt_in;
      out_msg_ff   <= out_msg_in;
      out_ip_ff    <= out_ip_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_links_ff <= out_links_in;
      out_full_ff  <= out_full_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_W'({out_links_ff, out_y_ff, out_x_ff, out_ip_ff,
                               out_msg_ff, out_tgt_ff});
   assign rsp_tuser  = {out_full_ff, out_kind_ff};
   assign rsp_tlast  = out_last_ff;

   // An accepted request always starts with the table write step.
   `GSA_ASSERT_NEXT(a_accept_to_write, clock, reset, req_accept, state_ff == S_WRITE, "accepted request did not enter the write step")
   // Advertisements never close a request and carry no slot.
   `GSA_ASSERT_SAME(a_advert_shape, clock, reset, rsp_tvalid && out_kind_ff == KIND_ADVERT, !rsp_tlast && out_x_ff == '0 && out_y_ff == '0 && !out_full_ff, "malformed advertisement")
   // A full-grid drop is a lone, final report.
   `GSA_ASSERT_SAME(a_full_report, clock, reset, rsp_tvalid && out_full_ff, rsp_tlast && out_kind_ff == KIND_REPORT && out_links_ff == '0, "malformed grid-full report")
   // The table is written only for a request that found a free slot.
   `GSA_ASSERT_SAME(a_write_has_slot, clock, reset, ram_we, state_ff == S_WRITE && !full_ff, "slot table written outside a placement")

endmodule

// ===== hdl/gsa_ram.sv =====
// ---------------------------------------------------------------------------
// gsa_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
module gsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gsa_cursor.sv =====
// ---------------------------------------------------------------------------
// gsa_cursor
// Tracks the next free slot of the growing square grid, shell by shell.
// ---------------------------------------------------------------------------
module gsa_cursor #(
   parameter int MAX_SIDE = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   output logic [$clog2(MAX_SIDE)-1:0] cur_x,
   output logic [$clog2(MAX_SIDE)-1:0] cur_y,
   output logic                        grid_full
);

   localparam int COORD_W = $clog2(MAX_SIDE);
   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int SLOTS   = MAX_SIDE * MAX_SIDE;
   localparam int CNT_W   = $clog2(SLOTS + 1);

   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [SIDE_W-1:0]  side_ff, side_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   side_sq;

   assign side_sq = CNT_W'(side_ff) * CNT_W'(side_ff);

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      side_in  = side_ff;
      count_in = count_ff;
      if (step) begin
         count_in = count_ff + CNT_W'(1);
         if (count_in == side_sq) begin
            // Shell complete: open the next one at the top of the new column.
            if (side_ff < SIDE_W'(MAX_SIDE)) begin
               side_in = side_ff + SIDE_W'(1);
               x_in    = COORD_W'(side_ff);
               y_in    = '0;
            end
         end else if (SIDE_W'(x_ff) == side_ff - SIDE_W'(1)) begin
            // Walking down the right column; turn into the bottom row.
            if ((SIDE_W + 1)'(y_ff) + (SIDE_W + 1)'(2) == (SIDE_W + 1)'(side_ff)) begin
               x_in = '0;
            end
            y_in = y_ff + COORD_W'(1);
         end else begin
            x_in = x_ff + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= '0;
         y_ff     <= '0;
         side_ff  <= SIDE_W'(1);
         count_ff <= '0;
      end else begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         side_ff  <= side_in;
         count_ff <= count_in;
      end
   end

   assign cur_x     = x_ff;
   assign cur_y     = y_ff;
   assign grid_full = (count_ff >= CNT_W'(SLOTS));

endmodule
